// ===== rtl/core/uadp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the UADP message header parser.
// No dependencies; used by uadp_parser, uadp_queue and the top level.
package uadp_pkg;

	localparam int QueueDepth = 2;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	typedef enum logic [3:0] {
		ERR_TRUNCATED   = 4'd0,
		ERR_FLAGS1      = 4'd1,
		ERR_PUBID_TYPE  = 4'd2,
		ERR_GROUP_OPTS  = 4'd3,
		ERR_MSG_COUNT   = 4'd4,
		ERR_INVALID     = 4'd5,
		ERR_ENCODING    = 4'd6,
		ERR_DSM_TYPE    = 4'd7,
		ERR_NONE        = 4'd8
	} err_code_t;

	typedef enum logic [17:0] {
		PH_VER     = 18'h00001,
		PH_FLAGS1  = 18'h00002,
		PH_PUBID   = 18'h00004,
		PH_GHDR    = 18'h00008,
		PH_GID     = 18'h00010,
		PH_GVER    = 18'h00020,
		PH_MSGCNT  = 18'h00040,
		PH_WRITER  = 18'h00080,
		PH_DSF1    = 18'h00100,
		PH_DSF2    = 18'h00200,
		PH_SEQ     = 18'h00400,
		PH_TS      = 18'h00800,
		PH_PICO    = 18'h01000,
		PH_STATUS  = 18'h02000,
		PH_MAJ     = 18'h04000,
		PH_MIN     = 18'h08000,
		PH_COUNT   = 18'h10000,
		PH_PAYLOAD = 18'h20000
	} phase_t;

	// option flag bits (some bits are reused once their first meaning is spent)
	localparam int OPT_PUB     = 0;
	localparam int OPT_GROUP   = 1;
	localparam int OPT_PAYLOAD = 2;
	localparam int OPT_FLAGS1  = 3;
	localparam int OPT_DSEQ    = 3;
	localparam int OPT_GID     = 4;
	localparam int OPT_GVER    = 5;
	localparam int OPT_GBAD    = 6;
	localparam int OPT_DSTAT   = 6;
	localparam int OPT_DMAJ    = 7;
	localparam int OPT_DMIN    = 8;
	localparam int OPT_DTS     = 9;
	localparam int OPT_DPICO   = 10;
	localparam int OPT_DSF2    = 11;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic        last_of_message;
		err_code_t   error_code;
		logic [7:0]  payload_byte;
		logic [3:0]  uadp_version;
		logic [3:0]  present_mask;
		logic [1:0]  publisher_id_size_code;
		logic [63:0] publisher_id;
		logic [15:0] wg_ident;
		logic [31:0] wg_revision;
		logic [15:0] dsw_ident;
		logic [15:0] field_count;
	} result_t;

endpackage

// ===== rtl/core/uadp_parser.sv =====
`timescale 1ns / 1ps
// Front end: walks the header one byte per accepted cycle into result records.
// Depends on uadp_pkg.
module uadp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_message,
	output logic               res_valid,
	output uadp_pkg::result_t  res
);

	typedef struct packed {
		uadp_pkg::phase_t ph;
		logic             fail;
	} walk_t;

	function automatic logic [4:0] ph_index(input uadp_pkg::phase_t p);
		logic [4:0] idx;
		idx = '0;
		for (int k = 0; k < 18; k++) begin
			if (p[k]) idx = idx | 5'(k);
		end
		return idx;
	endfunction

	// first present section at or after start
	function automatic walk_t walk(input logic [4:0] start, input logic [11:0] f);
		walk_t w;
		logic  done;
		logic  hit;
		w.ph = uadp_pkg::PH_COUNT;
		w.fail = 1'b0;
		done = 1'b0;
		for (int k = 1; k < 16; k++) begin
			hit = 1'b0;
			if (!done && start <= 5'(k)) begin
				case (k)
					1: hit = f[uadp_pkg::OPT_FLAGS1];
					2: hit = f[uadp_pkg::OPT_PUB];
					3: hit = f[uadp_pkg::OPT_GROUP];
					4: hit = f[uadp_pkg::OPT_GID];
					5: hit = f[uadp_pkg::OPT_GVER];
					6: begin
						if (f[uadp_pkg::OPT_GBAD]) w.fail = 1'b1;
						hit = f[uadp_pkg::OPT_GBAD] | f[uadp_pkg::OPT_PAYLOAD];
					end
					7: hit = f[uadp_pkg::OPT_PAYLOAD];
					8: hit = 1'b1;
					9: hit = f[uadp_pkg::OPT_DSF2];
					10: hit = f[uadp_pkg::OPT_DSEQ];
					11: hit = f[uadp_pkg::OPT_DTS];
					12: hit = f[uadp_pkg::OPT_DPICO];
					13: hit = f[uadp_pkg::OPT_DSTAT];
					14: hit = f[uadp_pkg::OPT_DMAJ];
					15: hit = f[uadp_pkg::OPT_DMIN];
					default: hit = 1'b0;
				endcase
				if (hit) begin
					done = 1'b1;
					w.ph = uadp_pkg::phase_t'(18'(1) << k);
				end
			end
		end
		return w;
	endfunction

	uadp_pkg::phase_t phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic        drop_q, drop_d;
	logic [11:0] flags_q, flags_d;
	logic [1:0]  idsz_q, idsz_d;
	logic [63:0] pub_q, pub_d;
	logic [15:0] gid_q, gid_d;
	logic [31:0] gver_q, gver_d;
	logic [15:0] wid_q, wid_d;
	logic [3:0]  ver_q, ver_d;
	logic [15:0] cnt_q, cnt_d;

	logic        err;
	uadp_pkg::err_code_t ecode;
	logic [2:0]  len_m1;
	logic [5:0]  sh;
	walk_t       w;
	logic        hdr;
	logic        out_v;
	uadp_pkg::result_t r;

	always_comb begin
		sh = {idx_q, 3'b000};
		phase_d = phase_q;
		idx_d = idx_q;
		drop_d = drop_q;
		flags_d = flags_q;
		idsz_d = idsz_q;
		pub_d = pub_q;
		gid_d = gid_q;
		gver_d = gver_q;
		wid_d = wid_q;
		ver_d = ver_q;
		cnt_d = cnt_q;
		err = 1'b0;
		ecode = uadp_pkg::ERR_NONE;
		hdr = 1'b0;
		out_v = 1'b0;
		w = '{ph: uadp_pkg::PH_COUNT, fail: 1'b0};
		len_m1 = 3'd0;

		r = '0;
		r.error_code = uadp_pkg::ERR_NONE;
		r.last_of_message = end_of_message;

		if (drop_q) begin
			if (end_of_message) begin
				drop_d = 1'b0;
				phase_d = uadp_pkg::PH_VER;
				idx_d = '0;
			end
		end else if (phase_q == uadp_pkg::PH_PAYLOAD) begin
			out_v = 1'b1;
			r.result_kind = uadp_pkg::KIND_PAYLOAD;
			r.payload_byte = rx_byte;
			if (end_of_message) begin
				phase_d = uadp_pkg::PH_VER;
				idx_d = '0;
			end
		end else begin
			case (phase_q)
				uadp_pkg::PH_VER: begin
					ver_d = rx_byte[3:0];
					flags_d = {8'd0, rx_byte[7:4]};
					idsz_d = '0;
					pub_d = '0;
					gid_d = '0;
					gver_d = '0;
					wid_d = '0;
					cnt_d = '0;
				end
				uadp_pkg::PH_FLAGS1: begin
					if (rx_byte[7:3] != 5'd0) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_FLAGS1;
					end else if (flags_q[uadp_pkg::OPT_PUB] && rx_byte[2]) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_PUBID_TYPE;
					end else if (!rx_byte[2]) begin
						idsz_d = rx_byte[1:0];
					end
				end
				uadp_pkg::PH_PUBID: pub_d = pub_q | (64'(rx_byte) << sh);
				uadp_pkg::PH_GHDR: begin
					if (rx_byte[0]) flags_d[uadp_pkg::OPT_GID] = 1'b1;
					if (rx_byte[1]) flags_d[uadp_pkg::OPT_GVER] = 1'b1;
					if (rx_byte[3:2] != 2'd0) flags_d[uadp_pkg::OPT_GBAD] = 1'b1;
				end
				uadp_pkg::PH_GID: gid_d = gid_q | 16'(16'(rx_byte) << sh[4:0]);
				uadp_pkg::PH_GVER: gver_d = gver_q | (32'(rx_byte) << sh[4:0]);
				uadp_pkg::PH_MSGCNT: begin
					if (rx_byte != 8'd1) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_MSG_COUNT;
					end
				end
				uadp_pkg::PH_WRITER: wid_d = wid_q | 16'(16'(rx_byte) << sh[4:0]);
				uadp_pkg::PH_DSF1: begin
					if (!rx_byte[0]) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_INVALID;
					end else if (rx_byte[2:1] != 2'd0) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_ENCODING;
					end else begin
						flags_d[uadp_pkg::OPT_DSEQ] = rx_byte[3];
						flags_d[uadp_pkg::OPT_DSTAT] = rx_byte[4];
						if (rx_byte[5]) flags_d[uadp_pkg::OPT_DMAJ] = 1'b1;
						if (rx_byte[6]) flags_d[uadp_pkg::OPT_DMIN] = 1'b1;
						if (rx_byte[7]) flags_d[uadp_pkg::OPT_DSF2] = 1'b1;
					end
				end
				uadp_pkg::PH_DSF2: begin
					if (rx_byte[3:0] != 4'd0) begin
						err = 1'b1;
						ecode = uadp_pkg::ERR_DSM_TYPE;
					end else begin
						if (rx_byte[4]) flags_d[uadp_pkg::OPT_DTS] = 1'b1;
						if (rx_byte[5]) flags_d[uadp_pkg::OPT_DPICO] = 1'b1;
					end
				end
				uadp_pkg::PH_COUNT: cnt_d = cnt_q | 16'(16'(rx_byte) << sh[4:0]);
				default: ;
			endcase

			case (phase_q)
				uadp_pkg::PH_PUBID: len_m1 = 3'((4'd1 << idsz_q) - 4'd1);
				uadp_pkg::PH_TS: len_m1 = 3'd7;
				uadp_pkg::PH_GVER, uadp_pkg::PH_MAJ, uadp_pkg::PH_MIN: len_m1 = 3'd3;
				uadp_pkg::PH_GID, uadp_pkg::PH_WRITER, uadp_pkg::PH_SEQ, uadp_pkg::PH_PICO,
				uadp_pkg::PH_STATUS, uadp_pkg::PH_COUNT: len_m1 = 3'd1;
				default: len_m1 = 3'd0;
			endcase

			if (!err) begin
				if (idx_q != len_m1) begin
					idx_d = idx_q + 3'd1;
				end else begin
					idx_d = '0;
					if (phase_q == uadp_pkg::PH_COUNT) begin
						hdr = 1'b1;
					end else begin
						w = walk(ph_index(phase_q) + 5'd1, flags_d);
						if (w.fail) begin
							err = 1'b1;
							ecode = uadp_pkg::ERR_GROUP_OPTS;
						end else begin
							phase_d = w.ph;
						end
					end
				end
			end

			if (err) begin
				out_v = 1'b1;
				r.result_kind = uadp_pkg::KIND_ERROR;
				r.error_code = ecode;
				phase_d = uadp_pkg::PH_VER;
				idx_d = '0;
				drop_d = !end_of_message;
			end else if (hdr) begin
				out_v = 1'b1;
				r.result_kind = uadp_pkg::KIND_HEADER;
				r.uadp_version = ver_d;
				r.present_mask = {flags_d[uadp_pkg::OPT_PAYLOAD],
					flags_d[uadp_pkg::OPT_GROUP] & flags_d[uadp_pkg::OPT_GVER],
					flags_d[uadp_pkg::OPT_GROUP] & flags_d[uadp_pkg::OPT_GID],
					flags_d[uadp_pkg::OPT_PUB]};
				r.publisher_id_size_code = flags_d[uadp_pkg::OPT_PUB] ? idsz_d : 2'd0;
				r.publisher_id = flags_d[uadp_pkg::OPT_PUB] ? pub_d : 64'd0;
				r.wg_ident = gid_d;
				r.wg_revision = gver_d;
				r.dsw_ident = wid_d;
				r.field_count = cnt_d;
				phase_d = end_of_message ? uadp_pkg::PH_VER : uadp_pkg::PH_PAYLOAD;
			end else if (end_of_message) begin
				out_v = 1'b1;
				r.result_kind = uadp_pkg::KIND_ERROR;
				r.error_code = uadp_pkg::ERR_TRUNCATED;
				phase_d = uadp_pkg::PH_VER;
				idx_d = '0;
			end
		end
	end

	assign res_valid = accept & out_v;
	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uadp_pkg::PH_VER;
			idx_q <= '0;
			drop_q <= 1'b0;
			flags_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			drop_q <= drop_d;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idsz_q <= idsz_d;
			pub_q <= pub_d;
			gid_q <= gid_d;
			gver_q <= gver_d;
			wid_q <= wid_d;
			ver_q <= ver_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/uadp_queue.sv =====
`timescale 1ns / 1ps
// Back end: short result queue whose head drives the output channel.
// Depends on uadp_pkg.
module uadp_queue #(
	parameter int Depth = uadp_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  uadp_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output uadp_pkg::result_t head
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	uadp_pkg::result_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == CW'(Depth));
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid & out_ready;
	assign head = mem_q[rd_q];

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= inc(wr_q);
			if (pop) rd_q <= inc(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== rtl/core/uadp_message_header_parser.sv =====
`timescale 1ns / 1ps
// Top level of the UADP network message header parser.
// Depends on uadp_pkg, uadp_parser and uadp_queue.
//
// Takes one message byte per request and walks the UADP headers: version and
// flags, extended flags 1, publisher id, group header, payload header and
// dataset flags, skipping unused optional fields. After the second byte of the
// field count it emits one header result; every later byte of the message is
// passed through as a payload result. An unsupported option or a message that
// ends early gives one error result, and the rest of that message is dropped.
// Throughput is one byte per clock: the header walk takes one state step per
// byte, so a byte is taken every cycle while the result queue (QueueDepth
// entries) has room. Results are registered in the queue before the output.
// Each byte produces at most one result.
module uadp_message_header_parser #(
	parameter int QueueDepth = uadp_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic        last_of_message,
	output logic [3:0]  error_code,
	output logic [7:0]  payload_byte,
	output logic [3:0]  uadp_version,
	output logic [3:0]  present_mask,
	output logic [1:0]  publisher_id_size_code,
	output logic [63:0] publisher_id,
	output logic [15:0] wg_ident,
	output logic [31:0] wg_revision,
	output logic [15:0] dsw_ident,
	output logic [15:0] field_count
);

	logic accept;
	logic full;
	logic res_valid;
	uadp_pkg::result_t res;
	uadp_pkg::result_t head;

	// a byte is only taken while a queue slot is free for its result
	assign in_ready = !full;
	assign accept = in_valid & in_ready;

	uadp_parser u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.end_of_message(end_of_message),
		.res_valid(res_valid),
		.res(res)
	);

	uadp_queue #(
		.Depth(QueueDepth)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res),
		.full(full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign result_kind = head.result_kind;
	assign last_of_message = head.last_of_message;
	assign error_code = head.error_code;
	assign payload_byte = head.payload_byte;
	assign uadp_version = head.uadp_version;
	assign present_mask = head.present_mask;
	assign publisher_id_size_code = head.publisher_id_size_code;
	assign publisher_id = head.publisher_id;
	assign wg_ident = head.wg_ident;
	assign wg_revision = head.wg_revision;
	assign dsw_ident = head.dsw_ident;
	assign field_count = head.field_count;

endmodule
